>>> rtl/core/dmbc_pkg.sv
package dmbc_pkg;

	localparam int DEF_ADDR_BITS   = 32;
	localparam int DEF_BLOCK_BYTES = 64;
	localparam int DEF_NUM_SLOTS   = 64;

	localparam int ADDR_W = 32;
	localparam int DATA_W = 8;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FILL  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic REG_READ_EN  = 1'b0;
	localparam logic REG_WRITE_EN = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/core/direct_mapped_block_cache_unit.sv
// Direct-mapped, write-through, write-allocate byte cache. Tags and valid bits live in one
// synchronous memory (one entry per slot), cached bytes in another (NUM_SLOTS*BLOCK_BYTES
// bytes); BLOCK_BYTES and NUM_SLOTS must be powers of two. A read or write is taken in one
// cycle and looked up in the next; in_ready stays low during the lookup, so a new access is
// not taken until the lookup has loaded a result or a fill request for output. A miss emits
// one fill request (kind 1, block base address) and then takes fill bytes (cmd 2) at one per
// cycle; after the last fill byte a finish state completes the pending access with a read
// result or a write-through once the output register is free. Reads and writes that arrive
// while a miss is pending, or while their enable register is zero, are dropped without a
// result. After reset, and after every clear command, the block writes every tag slot
// invalid with in_ready low; configuration writes are taken at any time.
module direct_mapped_block_cache_unit
	import dmbc_pkg::*;
#(
	parameter int ADDR_BITS   = DEF_ADDR_BITS,
	parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
	parameter int NUM_SLOTS   = DEF_NUM_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] wdata,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [ADDR_W-1:0] out_address,
	output logic [DATA_W-1:0] out_data,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic              cfg_data
);

	localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
	localparam int SLOT_BITS = $clog2(NUM_SLOTS);
	localparam int SLOT_IW   = (SLOT_BITS > 0) ? SLOT_BITS : 1;
	localparam int BIDX_W    = OFF_BITS + SLOT_BITS;
	localparam int BYTE_DEPTH = NUM_SLOTS * BLOCK_BYTES;
	localparam int EFF_AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int TAG_RAW   = EFF_AW - OFF_BITS - SLOT_BITS;
	localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? '1 :
		ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [ADDR_W-1:0] OFF_MASK  = ADDR_W'(BLOCK_BYTES - 1);
	localparam logic [ADDR_W-1:0] SLOT_MASK = ADDR_W'(NUM_SLOTS - 1);
	localparam logic [OFF_BITS-1:0] LAST_OFF = OFF_BITS'(BLOCK_BYTES - 1);
	localparam logic [SLOT_IW-1:0]  LAST_SLOT = SLOT_IW'(NUM_SLOTS - 1);

	function automatic logic [SLOT_IW-1:0] slot_of(input logic [ADDR_W-1:0] a);
		return SLOT_IW'((a >> OFF_BITS) & SLOT_MASK);
	endfunction

	function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a);
		return TAG_W'(a >> (OFF_BITS + SLOT_BITS));
	endfunction

	// memories: {valid, tag} per slot, bytes per slot and offset
	logic [TAG_W:0]      tag_mem [NUM_SLOTS];
	logic [DATA_W-1:0]   byte_mem [BYTE_DEPTH];

	state_t              state_q, state_nxt;
	logic [SLOT_IW-1:0]  clr_q;
	logic                read_en_q, write_en_q;
	logic                miss_pending_q;
	logic [OFF_BITS-1:0] fill_cnt_q;

	logic                pend_write_q;
	logic [ADDR_W-1:0]   pend_addr_q;
	logic [DATA_W-1:0]   pend_wdata_q;
	logic [DATA_W-1:0]   pend_rdata_q;

	logic                is_write_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [DATA_W-1:0]   data_s1;
	logic [TAG_W:0]      tag_rd_s1;
	logic [DATA_W-1:0]   byte_rd_s1;

	logic                out_valid_q;
	kind_t               kind_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [DATA_W-1:0]   out_data_q;

	logic [ADDR_W-1:0]   addr_in;
	logic                acc;
	logic                acc_clear, acc_fill, acc_access;
	logic                fill_last;
	logic [BIDX_W-1:0]   pend_bidx;
	logic [BIDX_W-1:0]   fill_pos;
	logic                hit;
	logic                out_free;

	logic                tag_we;
	logic [SLOT_IW-1:0]  tag_waddr;
	logic [TAG_W:0]      tag_wdata;
	logic                byte_we;
	logic [BIDX_W-1:0]   byte_waddr;
	logic [DATA_W-1:0]   byte_wdata;
	logic                res_load;
	kind_t               res_kind;
	logic [ADDR_W-1:0]   res_addr;
	logic [DATA_W-1:0]   res_data;
	logic                miss_start, miss_done;

	assign addr_in    = address & ADDR_MASK;
	assign acc        = in_valid && in_ready;
	assign acc_clear  = acc && (cmd == CMD_CLEAR);
	assign acc_fill   = acc && (cmd == CMD_FILL) && miss_pending_q;
	assign acc_access = acc && !miss_pending_q &&
		(((cmd == CMD_READ) && read_en_q) || ((cmd == CMD_WRITE) && write_en_q));
	assign fill_last  = (fill_cnt_q == LAST_OFF);
	assign pend_bidx  = pend_addr_q[BIDX_W-1:0];
	assign fill_pos   = (pend_bidx & ~BIDX_W'(BLOCK_BYTES - 1)) | BIDX_W'(fill_cnt_q);
	assign hit        = tag_rd_s1[TAG_W] && (tag_rd_s1[TAG_W-1:0] == tag_of(addr_s1));
	assign out_free   = !out_valid_q || out_ready;
	assign cfg_ready  = 1'b1;

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_address = out_addr_q;
	assign out_data    = out_data_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_SLOT)
					state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc_clear)
					state_nxt = ST_CLEAR;
				else if (acc_fill && fill_last)
					state_nxt = ST_FINISH;
				else if (acc_access)
					state_nxt = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			ST_FINISH: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// outputs and memory write controls
	always_comb begin
		in_ready   = 1'b0;
		tag_we     = 1'b0;
		tag_waddr  = clr_q;
		tag_wdata  = '0;
		byte_we    = 1'b0;
		byte_waddr = fill_pos;
		byte_wdata = wdata;
		res_load   = 1'b0;
		res_kind   = KIND_READ;
		res_addr   = addr_s1;
		res_data   = byte_rd_s1;
		miss_start = 1'b0;
		miss_done  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				tag_we = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				byte_we  = acc_fill;
			end
			ST_LOOKUP: begin
				if (out_free) begin
					res_load = 1'b1;
					if (hit && is_write_s1) begin
						byte_we    = 1'b1;
						byte_waddr = addr_s1[BIDX_W-1:0];
						byte_wdata = data_s1;
						res_kind   = KIND_WRITE;
						res_data   = data_s1;
					end else if (!hit) begin
						// slot goes invalid when the fill request is loaded into the output register
						tag_we     = 1'b1;
						tag_waddr  = slot_of(addr_s1);
						miss_start = 1'b1;
						res_kind   = KIND_FILL;
						res_addr   = addr_s1 & ~OFF_MASK;
						res_data   = '0;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					res_load  = 1'b1;
					miss_done = 1'b1;
					tag_we    = 1'b1;
					tag_waddr = slot_of(pend_addr_q);
					tag_wdata = {1'b1, tag_of(pend_addr_q)};
					res_addr  = pend_addr_q;
					if (pend_write_q) begin
						byte_we    = 1'b1;
						byte_waddr = pend_bidx;
						byte_wdata = pend_wdata_q;
						res_kind   = KIND_WRITE;
						res_data   = pend_wdata_q;
					end else begin
						res_kind = KIND_READ;
						res_data = pend_rdata_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[tag_waddr] <= tag_wdata;
		if (acc_access)
			tag_rd_s1 <= tag_mem[slot_of(addr_in)];
	end

	always_ff @(posedge clk) begin
		if (byte_we)
			byte_mem[byte_waddr] <= byte_wdata;
		if (acc_access)
			byte_rd_s1 <= byte_mem[addr_in[BIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			read_en_q      <= 1'b1;
			write_en_q     <= 1'b1;
			miss_pending_q <= 1'b0;
			fill_cnt_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (acc_clear)
				clr_q <= '0;
			else if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_READ_EN)
					read_en_q <= cfg_data;
				else
					write_en_q <= cfg_data;
			end

			if (acc_clear || miss_done)
				miss_pending_q <= 1'b0;
			else if (miss_start)
				miss_pending_q <= 1'b1;

			if (acc_clear || miss_start)
				fill_cnt_q <= '0;
			else if (acc_fill)
				fill_cnt_q <= fill_last ? '0 : fill_cnt_q + 1'b1;

			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_access) begin
			is_write_s1 <= (cmd == CMD_WRITE);
			addr_s1     <= addr_in;
			data_s1     <= wdata;
		end
		if (miss_start) begin
			pend_write_q <= is_write_s1;
			pend_addr_q  <= addr_s1;
			pend_wdata_q <= data_s1;
		end
		// keep the fill byte that a pending read asks for
		if (acc_fill && (fill_cnt_q == pend_addr_q[OFF_BITS-1:0]))
			pend_rdata_q <= wdata;
		if (res_load) begin
			kind_q     <= res_kind;
			out_addr_q <= res_addr;
			out_data_q <= res_data;
		end
	end

endmodule
